/* src/rectangle_pair_merge_assert.svh */
// ----------------------------------------------------------------------------
// rectangle_pair_merge assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_PAIR_MERGE_ASSERT_SVH
`define RECTANGLE_PAIR_MERGE_ASSERT_SVH

// same-cycle implication
`define RPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rpm_pkg.sv */
// ----------------------------------------------------------------------------
// rpm_pkg
// Types and constants shared by the rectangle pair merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpm_pkg;

    localparam int COORD_W         = 32;
    localparam int MAX_PIECES      = 3;
    localparam int PIECE_CNT_W     = $clog2(MAX_PIECES + 1);
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t bottom;
        coord_t right;
        coord_t top;
    } rect_t;

    // one classified pair: pieces in emit order, slot 0 first
    typedef struct packed {
        logic                         merged;
        logic [PIECE_CNT_W-1:0]       cnt;
        rect_t [MAX_PIECES-1:0]       piece;
    } q_entry_t;

    // queue status toward the back end
    typedef struct packed {
        logic     head_valid;
        q_entry_t head;
    } q_head_t;

endpackage

`default_nettype wire

/* src/rpm_if.sv */
// ----------------------------------------------------------------------------
// rpm_req_if / rpm_rsp_if
// Valid/ready channels carrying rectangle pairs in and pieces out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpm_req_if import rpm_pkg::*;;
    logic   valid;
    logic   ready;
    coord_t a_left;
    coord_t a_bottom;
    coord_t a_right;
    coord_t a_top;
    coord_t b_left;
    coord_t b_bottom;
    coord_t b_right;
    coord_t b_top;

    modport source (
        output valid, a_left, a_bottom, a_right, a_top,
               b_left, b_bottom, b_right, b_top,
        input  ready
    );
    modport sink (
        input  valid, a_left, a_bottom, a_right, a_top,
               b_left, b_bottom, b_right, b_top,
        output ready
    );
endinterface

interface rpm_rsp_if import rpm_pkg::*;;
    logic   valid;
    logic   ready;
    logic   did_merge;
    coord_t piece_left;
    coord_t piece_bottom;
    coord_t piece_right;
    coord_t piece_top;
    logic   last_piece;

    modport source (
        output valid, did_merge, piece_left, piece_bottom, piece_right,
               piece_top, last_piece,
        input  ready
    );
    modport sink (
        input  valid, did_merge, piece_left, piece_bottom, piece_right,
               piece_top, last_piece,
        output ready
    );
endinterface

`default_nettype wire

/* src/rectangle_pair_merge.sv */
// Rectangle pair merge. Each accepted word carries rectangles A and B and
// yields one to three result words: a single no-merge word, a single union,
// or for an overlap any top and bottom strips not folded into the band and
// then the middle band, with last_piece set on the final word of the pair.
// The front end classifies a pair in the cycle it is accepted and writes it
// to a small queue; it keeps accepting one pair per cycle while the queue
// has room. The back end moves one piece per cycle into the output register
// while that register is empty or its word is taken, and the first word of a
// pair passes through the queue and the output register before it appears.
// The output register refills in the same cycle its word is taken, so with
// ready held high the output runs at one word per cycle.
// ----------------------------------------------------------------------------
// rectangle_pair_merge
// Top level: front classifier, pair queue and piece emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_pair_merge import rpm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rpm_req_if.sink    req,
    rpm_rsp_if.source  rsp
);

    logic     push;
    logic     q_full;
    logic     pop;
    q_entry_t wr_entry;
    q_head_t  head;

    rpm_front u_front (
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .wr_entry (wr_entry)
    );

    rpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    rpm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

/* src/rpm_front.sv */
// ----------------------------------------------------------------------------
// rpm_front
// Accepts a rectangle pair, classifies it and builds the list of pieces.
// ----------------------------------------------------------------------------
`default_nettype none

module rpm_front import rpm_pkg::*;
(
    rpm_req_if.sink    req,
    input  wire logic  q_full,
    output logic       push,
    output q_entry_t   wr_entry
);

    function automatic coord_t cmin(input coord_t x, input coord_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic coord_t cmax(input coord_t x, input coord_t y);
        return (x > y) ? x : y;
    endfunction

    coord_t al, ab, ar, at, bl, bb, br, bt;
    coord_t ml, mr, mt, mb;
    logic   separated, same_lr, same_bt, touching;
    logic   has_top, has_bot, emit_top, emit_bot;
    rect_t  top_r, bot_r, band_r;

    assign al = req.a_left;
    assign ab = req.a_bottom;
    assign ar = req.a_right;
    assign at = req.a_top;
    assign bl = req.b_left;
    assign bb = req.b_bottom;
    assign br = req.b_right;
    assign bt = req.b_top;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    assign separated = (ar < bl) || (al > br) || (at < bb) || (ab > bt);
    assign same_lr   = (al == bl) && (ar == br);
    assign same_bt   = (ab == bb) && (at == bt);
    assign touching  = (ar <= bl) || (al >= br) || (at <= bb) || (ab >= bt);

    assign ml = cmin(al, bl);
    assign mr = cmax(ar, br);
    assign mt = cmin(at, bt);
    assign mb = cmax(ab, bb);

    always_comb
    begin
        has_top = (at != bt);
        if (bt > at)
        begin
            top_r = '{left: bl, bottom: at, right: br, top: bt};
        end
        else
        begin
            top_r = '{left: al, bottom: bt, right: ar, top: at};
        end

        has_bot = (ab != bb);
        if (bb < ab)
        begin
            bot_r = '{left: bl, bottom: bb, right: br, top: ab};
        end
        else
        begin
            bot_r = '{left: al, bottom: ab, right: ar, top: bb};
        end

        // a strip as wide as the band is folded into it
        emit_top = has_top && !((ml == top_r.left) && (mr == top_r.right));
        emit_bot = has_bot && !((ml == bot_r.left) && (mr == bot_r.right));

        band_r.left   = ml;
        band_r.right  = mr;
        band_r.top    = (has_top && !emit_top) ? top_r.top : mt;
        band_r.bottom = (has_bot && !emit_bot) ? bot_r.bottom : mb;
    end

    always_comb
    begin
        wr_entry        = '0;
        wr_entry.cnt    = PIECE_CNT_W'(1);
        if (separated)
        begin
            wr_entry.merged = 1'b0;
        end
        else if (same_lr)
        begin
            wr_entry.merged   = 1'b1;
            wr_entry.piece[0] = '{left: al, bottom: cmin(ab, bb), right: ar,
                                  top: cmax(at, bt)};
        end
        else if (same_bt)
        begin
            wr_entry.merged   = 1'b1;
            wr_entry.piece[0] = '{left: cmin(al, bl), bottom: ab,
                                  right: cmax(ar, br), top: at};
        end
        else if (touching)
        begin
            wr_entry.merged = 1'b0;
        end
        else
        begin
            wr_entry.merged   = 1'b1;
            wr_entry.cnt      = PIECE_CNT_W'(1) + PIECE_CNT_W'(emit_top)
                                + PIECE_CNT_W'(emit_bot);
            wr_entry.piece[0] = emit_top ? top_r : (emit_bot ? bot_r : band_r);
            wr_entry.piece[1] = (emit_top && emit_bot) ? bot_r : band_r;
            wr_entry.piece[2] = band_r;
        end
    end

endmodule

`default_nettype wire

/* src/rpm_queue.sv */
// ----------------------------------------------------------------------------
// rpm_queue
// Short FIFO of classified pairs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_pair_merge_assert.svh"

module rpm_queue import rpm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire q_entry_t  wr_entry,
    output logic           full,
    input  wire logic      pop,
    output q_head_t        head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full            = (cnt_reg == CW'(DEPTH));
    assign head.head_valid = (cnt_reg != '0);
    assign head.head       = mem_reg[rptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head.head_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wr_entry;
        end
    end

    `RPM_ASSERT_NOW(a_q_cnt_bound, 1'b1, cnt_reg <= CW'(DEPTH), "queue count above depth")
    `RPM_ASSERT_NEXT(a_q_push_only, do_push && !do_pop, cnt_reg != '0, "push lost in queue")
    `RPM_ASSERT_NEXT(a_q_full_holds, full && !do_pop, full, "full queue drained without pop")

endmodule

`default_nettype wire

/* src/rpm_back.sv */
// ----------------------------------------------------------------------------
// rpm_back
// Walks the pieces of the queue head and drives them out one per word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_pair_merge_assert.svh"

module rpm_back import rpm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_head_t  head,
    output logic          pop,
    rpm_rsp_if.source     rsp
);

    logic [PIECE_CNT_W-1:0] idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    rect_t                  out_rect_reg;
    logic                   out_merged_reg;
    logic                   out_last_reg;
    logic                   load, is_last;

    assign is_last = (idx_reg == head.head.cnt - 1'b1);
    assign load    = head.head_valid && (!out_valid_reg || rsp.ready);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rect_reg   <= head.head.piece[idx_reg];
            out_merged_reg <= head.head.merged;
            out_last_reg   <= is_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.did_merge    = out_merged_reg;
    assign rsp.piece_left   = out_rect_reg.left;
    assign rsp.piece_bottom = out_rect_reg.bottom;
    assign rsp.piece_right  = out_rect_reg.right;
    assign rsp.piece_top    = out_rect_reg.top;
    assign rsp.last_piece   = out_last_reg;

    `RPM_ASSERT_NOW(a_cnt_nonzero, head.head_valid,
        (head.head.cnt != '0) && (head.head.cnt <= PIECE_CNT_W'(MAX_PIECES)),
        "bad piece count")
    `RPM_ASSERT_NOW(a_idx_in_range, head.head_valid, idx_reg < head.head.cnt,
        "piece index past count")
    `RPM_ASSERT_NOW(a_nomerge_single, out_valid_reg && !out_merged_reg,
        out_last_reg && (out_rect_reg == '0), "no-merge word not single zero piece")

endmodule

`default_nettype wire
